// ===== sv/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types and constants for the serial line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int SLE_LINE_BUFFER_BYTES = 64;

  localparam logic [7:0] CODE_BS    = 8'h08;
  localparam logic [7:0] CODE_LF    = 8'h0A;
  localparam logic [7:0] CODE_CR    = 8'h0D;
  localparam logic [7:0] CODE_ESC   = 8'h1B;
  localparam logic [7:0] CODE_SPACE = 8'h20;
  localparam logic [7:0] CODE_DEL   = 8'h7F;

  localparam logic [3:0] CANCEL_LEN = 4'd15;
  localparam logic [7:0] CANCEL_TEXT [15] = '{
    8'h0D, 8'h0A, 8'h5B, 8'h43, 8'h61, 8'h6E, 8'h63, 8'h65,
    8'h6C, 8'h6C, 8'h65, 8'h64, 8'h5D, 8'h0D, 8'h0A
  };

  // Command kinds produced by the front end
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_EOL,
    CMD_ERASE,
    CMD_ESC,
    CMD_CHAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  // Echo text selector
  typedef enum logic [1:0] {
    ECHO_CRLF,
    ECHO_ERASE,
    ECHO_CANCEL,
    ECHO_CHAR
  } echo_sel_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } back_state_t;

endpackage

// ===== sv/sle_front.sv =====
// ----------------------------------------------------------------------------
// sle_front
// Accepts received bytes and classifies them into editor commands.
// ----------------------------------------------------------------------------
module sle_front import sle_pkg::*; (
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  cmd_kind_t kind;

  always_comb begin
    priority if (in_tdata == CODE_CR || in_tdata == CODE_LF) begin
      kind = CMD_EOL;
    end else if (in_tdata == CODE_BS || in_tdata == CODE_DEL) begin
      kind = CMD_ERASE;
    end else if (in_tdata == CODE_ESC) begin
      kind = CMD_ESC;
    end else if (in_tdata < CODE_SPACE) begin
      kind = CMD_NONE;             // other control codes dropped
    end else begin
      kind = CMD_CHAR;
    end
  end

  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && !q_full && (kind != CMD_NONE);
  assign q_cmd.kind = kind;
  assign q_cmd.data = in_tdata;

endmodule

// ===== sv/sle_queue.sv =====
// ----------------------------------------------------------------------------
// sle_queue
// Two-entry command queue between front end and back end.
// ----------------------------------------------------------------------------
module sle_queue import sle_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = !wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = !rd_ptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/sle_back.sv =====
// ----------------------------------------------------------------------------
// sle_back
// Executes commands: owns line store and fill index, emits result words.
// ----------------------------------------------------------------------------
module sle_back import sle_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = SLE_LINE_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  localparam int IDX_W = $clog2(LINE_BUFFER_BYTES);
  localparam int K_W   = $clog2(LINE_BUFFER_BYTES > 16 ? LINE_BUFFER_BYTES : 16);
  localparam logic [IDX_W-1:0] FULL_FILL = IDX_W'(LINE_BUFFER_BYTES - 1);

  function automatic logic [3:0] echo_count(echo_sel_t sel);
    logic [3:0] n;
    unique case (sel)
      ECHO_CRLF:   n = 4'd2;
      ECHO_ERASE:  n = 4'd3;
      ECHO_CANCEL: n = CANCEL_LEN;
      ECHO_CHAR:   n = 4'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] echo_lookup(echo_sel_t sel, logic [3:0] idx,
                                             logic [7:0] ch);
    logic [7:0] b;
    unique case (sel)
      ECHO_CRLF:   b = idx[0] ? CODE_LF : CODE_CR;
      ECHO_ERASE:  b = (idx == 4'd1) ? CODE_SPACE : CODE_BS;
      ECHO_CANCEL: b = (idx < CANCEL_LEN) ? CANCEL_TEXT[idx] : 8'h00;
      ECHO_CHAR:   b = ch;
    endcase
    return b;
  endfunction

  logic [7:0] store [LINE_BUFFER_BYTES];

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [K_W-1:0]   last_k_r, last_k_nxt;
  logic [IDX_W-1:0] nline_r, nline_nxt;
  echo_sel_t        sel_r, sel_nxt;
  logic             end_r, end_nxt;
  logic             cancel_r, cancel_nxt;
  logic [7:0]       ch_r, ch_nxt;

  // output register
  logic             ov_r, ov_nxt;
  logic             echo_v_r, echo_v_nxt;
  logic [7:0]       echo_b_r, echo_b_nxt;
  logic             line_v_r, line_v_nxt;
  logic             line_end_r, line_end_nxt;
  logic [5:0]       len_r, len_nxt;
  logic             canc_r, canc_nxt;
  logic             last_r, last_nxt;
  logic [7:0]       rd_q_r;

  logic adv, fin, mem_we, rd_en;

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    k_nxt        = k_r;
    last_k_nxt   = last_k_r;
    nline_nxt    = nline_r;
    sel_nxt      = sel_r;
    end_nxt      = end_r;
    cancel_nxt   = cancel_r;
    ch_nxt       = ch_r;
    ov_nxt       = ov_r;
    echo_v_nxt   = echo_v_r;
    echo_b_nxt   = echo_b_r;
    line_v_nxt   = line_v_r;
    line_end_nxt = line_end_r;
    len_nxt      = len_r;
    canc_nxt     = canc_r;
    last_nxt     = last_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    adv          = !ov_r || out_tready;
    fin          = (k_r == last_k_r);

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          ch_nxt     = q_cmd.data;
          end_nxt    = 1'b0;
          cancel_nxt = 1'b0;
          nline_nxt  = '0;
          k_nxt      = '0;
          unique case (q_cmd.kind)
            CMD_NONE: begin
            end
            CMD_EOL: begin
              sel_nxt    = ECHO_CRLF;
              end_nxt    = 1'b1;
              nline_nxt  = fill_r;
              fill_nxt   = '0;
              last_k_nxt = (fill_r > IDX_W'(1)) ? K_W'(fill_r) - K_W'(1) : K_W'(1);
              state_nxt  = ST_EMIT;
            end
            CMD_ERASE: begin
              if (fill_r != '0) begin
                fill_nxt   = fill_r - IDX_W'(1);
                sel_nxt    = ECHO_ERASE;
                last_k_nxt = K_W'(2);
                state_nxt  = ST_EMIT;
              end
            end
            CMD_ESC: begin
              sel_nxt    = ECHO_CANCEL;
              end_nxt    = 1'b1;
              cancel_nxt = 1'b1;
              fill_nxt   = '0;
              last_k_nxt = K_W'(CANCEL_LEN) - K_W'(1);
              state_nxt  = ST_EMIT;
            end
            CMD_CHAR: begin
              mem_we    = 1'b1;
              sel_nxt   = ECHO_CHAR;
              state_nxt = ST_EMIT;
              if (fill_r + IDX_W'(1) == FULL_FILL) begin
                // line reaches LINE_BUFFER_BYTES - 1 bytes: line completes without CR LF
                end_nxt    = 1'b1;
                nline_nxt  = FULL_FILL;
                fill_nxt   = '0;
                last_k_nxt = K_W'(fill_r);
              end else begin
                fill_nxt   = fill_r + IDX_W'(1);
                last_k_nxt = '0;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (adv) begin
          rd_en        = 1'b1;
          ov_nxt       = 1'b1;
          echo_v_nxt   = k_r < K_W'(echo_count(sel_r));
          echo_b_nxt   = (k_r < K_W'(echo_count(sel_r))) ?
                         echo_lookup(sel_r, k_r[3:0], ch_r) : 8'h00;
          line_v_nxt   = k_r < K_W'(nline_r);
          line_end_nxt = fin && end_r;
          len_nxt      = (fin && end_r) ? 6'(nline_r) : 6'd0;
          canc_nxt     = fin && end_r && cancel_r;
          last_nxt     = fin;
          if (fin) begin
            state_nxt = ST_IDLE;
            k_nxt     = '0;
          end else begin
            k_nxt = k_r + K_W'(1);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_k_r   <= last_k_nxt;
    nline_r    <= nline_nxt;
    sel_r      <= sel_nxt;
    end_r      <= end_nxt;
    cancel_r   <= cancel_nxt;
    ch_r       <= ch_nxt;
    echo_v_r   <= echo_v_nxt;
    echo_b_r   <= echo_b_nxt;
    line_v_r   <= line_v_nxt;
    line_end_r <= line_end_nxt;
    len_r      <= len_nxt;
    canc_r     <= canc_nxt;
    last_r     <= last_nxt;
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[fill_r] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= store[k_r[IDX_W-1:0]];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {6'd0, canc_r, len_r, line_end_r,
                       (line_v_r ? rd_q_r : 8'h00), line_v_r,
                       echo_b_r, echo_v_r};

endmodule

// ===== sv/serial_line_editor.sv =====
// ----------------------------------------------------------------------------
// serial_line_editor
// Terminal line editor with echo: edits, completes and streams input lines.
// ----------------------------------------------------------------------------
// in_*  : one received byte per word; control codes other than BS, DEL, CR,
//         LF and ESC are taken and dropped.
// out_* : result words, each with one echo byte and one line byte side by
//         side; out_tlast marks the final word for an input byte, and the
//         end flag, length and cancel flag ride on it.
// Path: an accepted byte is written into the command queue, the back end
//   pops it when idle and enters its emit state, and each result word is
//   loaded into the output register there.
// Throughput: one result word per cycle while out_tready is high; the back
//   end pops the next command only after loading the final word of a
//   printable byte, erase, ESC or completion (CR LF beside the stored bytes).
// The two-entry queue keeps taking bytes while a line streams out;
//   in_tready drops only when the queue is full.
// Reset: fill index cleared, queue emptied, nothing pending; the line store
//   is not cleared, only written entries ever reach line_byte.
// Stall: with out_tready low the current word holds and the back end waits.
// ----------------------------------------------------------------------------
module serial_line_editor import sle_pkg::*; #(
  parameter int LINE_BUFFER_BYTES = SLE_LINE_BUFFER_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] echo_valid, [8:1] echo_byte, [9] line_valid, [17:10] line_byte,
  // [18] line_end, [24:19] line_length, [25] cancelled, [31:26] zero
  output logic [31:0] out_tdata,
  output logic        out_tlast    // last
);

  logic q_full, q_push, q_pop, q_empty;
  cmd_t push_cmd, pop_cmd;

  sle_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  sle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  sle_back #(
    .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
